/* rtl/ild_pkg.sv */
// ----------------------------------------------------------------------------
// ild_pkg: shared definitions for the IIR lowpass decimator
// Tap counts, coefficient table, control structs and sequencer states.
// ----------------------------------------------------------------------------
package ild_pkg;

  // Filter geometry.
  localparam int FF_TAPS    = 10;
  localparam int FB_TAPS    = 9;
  localparam int N_TAPS     = FF_TAPS + FB_TAPS;
  localparam int DECIMATION = 5;
  localparam int PHASE_W    = 3;
  localparam int STEP_W     = 5;
  localparam int DATA_W     = 32;
  localparam int SAMPLE_W   = 16;
  localparam int ACC_W      = 64;

  // Coefficients in signed Q6.26: feedforward b0..b9, then feedback a0..a8.
  localparam logic signed [DATA_W-1:0] COEF_TABLE [N_TAPS] = '{
    32'sd639172, 32'sd142802, 32'sd1877982, 32'sd1095906, 32'sd2155183,
    32'sd2155183, 32'sd1095906, 32'sd1877982, 32'sd142802, 32'sd639172,
    -32'sd289063040, 32'sd719449920, -32'sd1194942080, 32'sd1450737280,
    -32'sd1309585408, 32'sd880117824, -32'sd424878144, 32'sd135431648,
    -32'sd22554624
  };

  // Coefficient lookup by tap index.
  function automatic logic signed [DATA_W-1:0] coef_at(input logic [STEP_W-1:0] idx);
    logic signed [DATA_W-1:0] c;
    c = '0;
    for (int i = 0; i < N_TAPS; i++) begin
      if (idx == STEP_W'(i)) begin
        c = COEF_TABLE[i];
      end
    end
    return c;
  endfunction

  // Control of one history cell.
  typedef struct packed {
    logic shift;  // take the neighbor's value
    logic zero;   // take zero instead
  } cell_ctl_t;

  // Control of one multiply-accumulate issue.
  typedef struct packed {
    logic valid;  // a product is issued this cycle
    logic first;  // first tap of a sample: restart the accumulator
    logic fb;     // feedback tap: floor by 2^10 instead of scaling by 2^6
  } mac_ctl_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT,
    ST_DONE
  } state_t;

endpackage

/* rtl/ild_ifs.sv */
// ----------------------------------------------------------------------------
// ild_ifs: channel interfaces of the IIR lowpass decimator
// Input sample channel and filtered result channel, valid/ready handshake.
// ----------------------------------------------------------------------------

// Input sample channel.
interface ild_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [ild_pkg::SAMPLE_W-1:0]   sample_in;
  logic                                  clear_history;
  logic                                  last_in_block;

  modport source (output valid, output sample_in, output clear_history,
                  output last_in_block, input ready);
  modport sink   (input valid, input sample_in, input clear_history,
                  input last_in_block, output ready);
endinterface

// Filtered result channel.
interface ild_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [ild_pkg::DATA_W-1:0]     filtered_out;

  modport source (output valid, output filtered_out, input ready);
  modport sink   (input valid, input filtered_out, output ready);
endinterface

/* rtl/ild_cell.sv */
// ----------------------------------------------------------------------------
// ild_cell: one history cell
// Holds one history entry and takes its neighbor's value when told to shift.
// ----------------------------------------------------------------------------
module ild_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ild_pkg::cell_ctl_t              ctl,
  input  logic [ild_pkg::DATA_W-1:0]      d_prev,
  output logic [ild_pkg::DATA_W-1:0]      q
);

  logic [ild_pkg::DATA_W-1:0] q_r;
  logic [ild_pkg::DATA_W-1:0] q_nxt;

  // Shift in the neighbor's value, or zero when the history is cleared.
  always_comb begin
    q_nxt = q_r;
    if (ctl.shift) begin
      q_nxt = ctl.zero ? '0 : d_prev;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

/* rtl/ild_mac.sv */
// ----------------------------------------------------------------------------
// ild_mac: shared multiply-accumulate with rounding and saturation
// One registered 32x32 product per cycle, a 64-bit Q.32 accumulator, and
// round-half-up to saturated Q16.16.
// ----------------------------------------------------------------------------
module ild_mac (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  ild_pkg::mac_ctl_t                     ctl,
  input  logic signed [ild_pkg::DATA_W-1:0]     opa,
  input  logic signed [ild_pkg::DATA_W-1:0]     coef,
  output logic signed [ild_pkg::DATA_W-1:0]     y
);

  logic signed [ild_pkg::ACC_W-1:0] prod_r;
  logic signed [ild_pkg::ACC_W-1:0] prod_nxt;
  ild_pkg::mac_ctl_t                pctl_r;
  logic signed [ild_pkg::ACC_W-1:0] acc_r;
  logic signed [ild_pkg::ACC_W-1:0] acc_nxt;
  logic signed [ild_pkg::ACC_W-1:0] term;
  logic signed [ild_pkg::ACC_W-1:0] rnd;
  logic signed [ild_pkg::ACC_W-1:0] shifted;
  logic                             in_range;

  // Product stage.
  assign prod_nxt = ild_pkg::ACC_W'(opa) * ild_pkg::ACC_W'(coef);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pctl_r <= '0;
    end else begin
      pctl_r <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  // Align the product to Q.32: feedforward is exact, feedback is floored.
  assign term = pctl_r.fb ? (prod_r >>> 10) : (prod_r <<< 6);

  // Accumulate stage: feedforward terms are added, feedback terms subtracted.
  always_comb begin
    acc_nxt = acc_r;
    if (pctl_r.valid) begin
      if (pctl_r.first) begin
        acc_nxt = term;
      end else if (pctl_r.fb) begin
        acc_nxt = acc_r - term;
      end else begin
        acc_nxt = acc_r + term;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // Round half up to Q16.16 and saturate to 32 bits.
  assign rnd      = acc_r + 64'sd32768;
  assign shifted  = rnd >>> 16;
  assign in_range = (&shifted[ild_pkg::ACC_W-1:ild_pkg::DATA_W-1]) |
                    ~(|shifted[ild_pkg::ACC_W-1:ild_pkg::DATA_W-1]);

  always_comb begin
    if (in_range) begin
      y = shifted[ild_pkg::DATA_W-1:0];
    end else if (shifted[ild_pkg::ACC_W-1]) begin
      y = {1'b1, {(ild_pkg::DATA_W-1){1'b0}}};
    end else begin
      y = {1'b0, {(ild_pkg::DATA_W-1){1'b1}}};
    end
  end

endmodule

/* rtl/iir_lowpass_decimator_unit.sv */
// ----------------------------------------------------------------------------
// iir_lowpass_decimator_unit: ninth-order IIR lowpass, decimate by five
// Direct-form-I filter over two rotating rings of history cells and one
// shared multiply-accumulate.
// ----------------------------------------------------------------------------
// Each accepted sample is first shifted into the input ring (ST_IDLE). Then
// both rings rotate past the single shared multiplier one tap at a time
// (ST_RUN), the product and accumulate registers settle (ST_WAIT), and the
// result is written back into the output ring (ST_DONE); only after that is
// the next sample taken. A result is produced for every fifth
// sample of a block (when the phase is zero) and waits in an output register,
// so the next sample is already being filtered while it is taken; only when a
// new result is ready while the previous one is still untaken does the block
// hold until that transfer. Clear restarts both histories and the phase
// before its sample is used; a last-in-block sample restarts the phase after.
// ----------------------------------------------------------------------------
module iir_lowpass_decimator_unit (
  input  logic      clk,
  input  logic      rst_n,
  ild_in_if.sink    in_ch,
  ild_out_if.source out_ch
);

  localparam int FF = ild_pkg::FF_TAPS;
  localparam int FB = ild_pkg::FB_TAPS;

  ild_pkg::state_t                       state_r;
  ild_pkg::state_t                       state_nxt;
  logic [ild_pkg::STEP_W-1:0]            step_r;
  logic [ild_pkg::PHASE_W-1:0]           phase_r;
  logic [ild_pkg::PHASE_W-1:0]           phase_eff;
  logic [ild_pkg::PHASE_W:0]             phase_inc;
  logic                                  emit_r;
  logic                                  out_valid_r;
  logic                                  out_valid_nxt;
  logic signed [ild_pkg::DATA_W-1:0]     out_data_r;

  logic                                  in_ready;
  logic                                  accept;
  logic                                  can_finish;
  logic                                  out_load;
  logic                                  in_phase;

  ild_pkg::cell_ctl_t                    in_ctl  [FF];
  ild_pkg::cell_ctl_t                    out_ctl [FB];
  logic [ild_pkg::DATA_W-1:0]            in_q    [FF];
  logic [ild_pkg::DATA_W-1:0]            out_q   [FB];
  logic [ild_pkg::DATA_W-1:0]            in_d0;
  logic [ild_pkg::DATA_W-1:0]            out_d0;

  ild_pkg::mac_ctl_t                     mac_ctl;
  logic signed [ild_pkg::DATA_W-1:0]     mac_opa;
  logic signed [ild_pkg::DATA_W-1:0]     mac_coef;
  logic [ild_pkg::STEP_W-1:0]            coef_idx;
  logic signed [ild_pkg::DATA_W-1:0]     y;

  // Input ring: newest sample in cell 0, sign-extended to cell width.
  for (genvar i = 0; i < FF; i++) begin : g_in_ring
    if (i == 0) begin : g_head
      ild_cell u_cell (.clk(clk), .rst_n(rst_n), .ctl(in_ctl[i]),
                       .d_prev(in_d0), .q(in_q[i]));
    end else begin : g_body
      ild_cell u_cell (.clk(clk), .rst_n(rst_n), .ctl(in_ctl[i]),
                       .d_prev(in_q[i-1]), .q(in_q[i]));
    end
  end

  // Output ring: newest filter output in cell 0.
  for (genvar i = 0; i < FB; i++) begin : g_out_ring
    if (i == 0) begin : g_head
      ild_cell u_cell (.clk(clk), .rst_n(rst_n), .ctl(out_ctl[i]),
                       .d_prev(out_d0), .q(out_q[i]));
    end else begin : g_body
      ild_cell u_cell (.clk(clk), .rst_n(rst_n), .ctl(out_ctl[i]),
                       .d_prev(out_q[i-1]), .q(out_q[i]));
    end
  end

  // Shared multiply-accumulate.
  ild_mac u_mac (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (mac_ctl),
    .opa  (mac_opa),
    .coef (mac_coef),
    .y    (y)
  );

  // The ring tails present the oldest entry first; tap index counts down.
  assign in_phase = (step_r < ild_pkg::STEP_W'(FF));
  assign coef_idx = in_phase ? ild_pkg::STEP_W'(FF - 1) - step_r
                             : ild_pkg::STEP_W'(2 * FF + FB - 1) - step_r;
  assign mac_opa  = in_phase ? $signed(in_q[FF-1]) : $signed(out_q[FB-1]);
  assign mac_coef = ild_pkg::coef_at(coef_idx);

  assign accept     = in_ch.valid && in_ready;
  assign can_finish = !emit_r || !out_valid_r || out_ch.ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ild_pkg::ST_IDLE: begin
        if (in_ch.valid) state_nxt = ild_pkg::ST_RUN;
      end
      ild_pkg::ST_RUN: begin
        if (step_r == ild_pkg::STEP_W'(ild_pkg::N_TAPS - 1)) state_nxt = ild_pkg::ST_WAIT;
      end
      ild_pkg::ST_WAIT: begin
        state_nxt = ild_pkg::ST_DONE;
      end
      ild_pkg::ST_DONE: begin
        if (can_finish) state_nxt = ild_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = ild_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer: ring controls, issue and result load.
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    mac_ctl  = '0;
    in_d0    = in_q[FF-1];
    out_d0   = out_q[FB-1];
    for (int i = 0; i < FF; i++) in_ctl[i] = '0;
    for (int i = 0; i < FB; i++) out_ctl[i] = '0;
    unique case (state_r)
      ild_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          // Shift the sample in; a clear zeroes every other entry.
          in_d0 = {{(ild_pkg::DATA_W - ild_pkg::SAMPLE_W){in_ch.sample_in[ild_pkg::SAMPLE_W-1]}},
                   in_ch.sample_in};
          for (int i = 0; i < FF; i++) begin
            in_ctl[i].shift = 1'b1;
            in_ctl[i].zero  = (i != 0) && in_ch.clear_history;
          end
          for (int i = 0; i < FB; i++) begin
            out_ctl[i].shift = in_ch.clear_history;
            out_ctl[i].zero  = in_ch.clear_history;
          end
        end
      end
      ild_pkg::ST_RUN: begin
        mac_ctl.valid = 1'b1;
        mac_ctl.first = (step_r == '0);
        mac_ctl.fb    = !in_phase;
        for (int i = 0; i < FF; i++) in_ctl[i].shift = in_phase;
        for (int i = 0; i < FB; i++) out_ctl[i].shift = !in_phase;
      end
      ild_pkg::ST_WAIT: begin
        mac_ctl = '0;
      end
      ild_pkg::ST_DONE: begin
        if (can_finish) begin
          // Write the filter output back into the feedback history.
          out_d0   = y;
          out_load = emit_r;
          for (int i = 0; i < FB; i++) out_ctl[i].shift = 1'b1;
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign in_ch.ready = in_ready;

  // Phase after this sample, counted from the cleared phase if asked.
  assign phase_eff = in_ch.clear_history ? '0 : phase_r;
  assign phase_inc = {1'b0, phase_eff} + 1'b1;

  // Sequencer, step counter and phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ild_pkg::ST_IDLE;
      step_r  <= '0;
      phase_r <= '0;
      emit_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= (state_r == ild_pkg::ST_RUN) ? step_r + 1'b1 : '0;
      if (accept) begin
        emit_r <= (phase_eff == '0);
        if (in_ch.last_in_block ||
            phase_inc >= (ild_pkg::PHASE_W + 1)'(ild_pkg::DECIMATION)) begin
          phase_r <= '0;
        end else begin
          phase_r <= phase_inc[ild_pkg::PHASE_W-1:0];
        end
      end
    end
  end

  // Output register: a result waits here until its transfer.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;
    if (out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= y;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.filtered_out = out_data_r;

endmodule

/* dv/ild_result_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ild_result_checker: prediction and scoreboard for the IIR decimator
// Watches the sample and result channels. Each sample transfer runs through
// a fixed-point model of the ninth-order filter and its decimation phase, and
// each emitted value is queued. Each result transfer is compared against the
// oldest queued value. The mismatch count and the queue depth go to the top.
// ----------------------------------------------------------------------------
module ild_result_checker (
  input  logic clk,
  input  logic rst_n,
  ild_in_if    in_ch,
  ild_out_if   out_ch,
  output int   mismatch_count,
  output int   results_pending
);

  localparam int FF_N         = 10;
  localparam int FB_N         = 9;
  localparam int DECIM_FACTOR = 5;

  // Q6.26 coefficients. The feedforward set is symmetric.
  localparam int FF_COEF [FF_N] = '{
    639172, 142802, 1877982, 1095906, 2155183,
    2155183, 1095906, 1877982, 142802, 639172
  };
  localparam int FB_COEF [FB_N] = '{
    -289063040, 719449920, -1194942080, 1450737280, -1309585408,
    880117824, -424878144, 135431648, -22554624
  };

  localparam longint Y_MAX = 64'sd2147483647;
  localparam longint Y_MIN = -64'sd2147483648;

  // Model state: newest entry at index 0.
  logic signed [15:0] x_hist [FF_N];
  logic signed [31:0] y_hist [FB_N];
  logic [2:0]         dec_phase;

  // Filter outputs that are still waiting for their result transfer.
  logic signed [31:0] predicted_samples [$];

  logic signed [31:0] new_y;
  logic signed [31:0] oldest;
  bit                 emits;

  // Zero both histories and the phase.
  task automatic clear_filter();
    for (int i = 0; i < FF_N; i++) x_hist[i] = '0;
    for (int i = 0; i < FB_N; i++) y_hist[i] = '0;
    dec_phase = '0;
  endtask

  // Run one sample through the filter and advance the decimation phase.
  task automatic advance_filter(input logic signed [15:0] sample, input logic clr,
                                input logic last, output bit emit,
                                output logic signed [31:0] y);
    longint acc;
    longint prod;
    longint rounded;
    if (clr) clear_filter();

    for (int i = FF_N - 1; i > 0; i--) x_hist[i] = x_hist[i-1];
    x_hist[0] = sample;

    // Feedforward products are exact in Q.26 and move up to Q.32.
    acc = 0;
    for (int i = 0; i < FF_N; i++) begin
      acc += (longint'(x_hist[i]) * longint'(FF_COEF[i])) * 64;
    end
    // Feedback products are floored from Q.42 down to Q.32.
    for (int k = 0; k < FB_N; k++) begin
      prod = longint'(y_hist[k]) * longint'(FB_COEF[k]);
      acc -= prod >>> 10;
    end

    // Round half up to Q16.16, then saturate.
    rounded = (acc + 64'sd32768) >>> 16;
    if (rounded > Y_MAX) rounded = Y_MAX;
    else if (rounded < Y_MIN) rounded = Y_MIN;
    y = rounded[31:0];

    emit = (dec_phase == 3'd0);

    for (int k = FB_N - 1; k > 0; k--) y_hist[k] = y_hist[k-1];
    y_hist[0] = y;

    if (last || (int'(dec_phase) + 1 >= DECIM_FACTOR)) dec_phase = '0;
    else dec_phase = dec_phase + 3'd1;
  endtask

  // Results are checked before the sample of the same edge is taken, so a
  // result cannot be matched against a sample that arrives with it.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_filter();
      predicted_samples.delete();
      results_pending = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (predicted_samples.size() == 0) begin
          $display("%0t: unexpected result transfer, expected none, actual %0d",
                   $time, out_ch.filtered_out);
          mismatch_count++;
        end else begin
          oldest = predicted_samples.pop_front();
          if (out_ch.filtered_out !== oldest) begin
            $display("%0t: filtered_out mismatch, expected %0d, actual %0d",
                     $time, oldest, out_ch.filtered_out);
            mismatch_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        advance_filter(in_ch.sample_in, in_ch.clear_history, in_ch.last_in_block,
                       emits, new_y);
        if (emits) predicted_samples.push_back(new_y);
      end
      results_pending = predicted_samples.size();
    end
  end

endmodule

/* dv/tb_iir_lowpass_decimator_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_iir_lowpass_decimator_unit: top level of the IIR decimator testbench
// Drives directed and random sample blocks through four flow-control phases,
// lets the result side stall at random, and reports the verdict from the
// checker's mismatch count once every predicted result has arrived.
// ----------------------------------------------------------------------------
module tb_iir_lowpass_decimator_unit;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int ITEMS_PER_MODE = 125;

  typedef enum logic [1:0] {
    FLOW_FREE,
    FLOW_SEND_IDLE,
    FLOW_RECV_STALL,
    FLOW_BOTH
  } flow_mode_e;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_took = 1'b0;
  flow_mode_e flow_mode = FLOW_FREE;
  int         mismatches;
  int         pending;
  int         cycle_count = 0;
  int         samples_sent = 0;

  ild_in_if  in_ch ();
  ild_out_if out_ch ();

  iir_lowpass_decimator_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ild_result_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .mismatch_count  (mismatches),
    .results_pending (pending)
  );

  always #1 clk = ~clk;

  // Run limit, in case the block stops moving.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL iir_lowpass_decimator_unit");
      $finish;
    end
  end

  // Remember whether a sample transfer took place at the last rising edge.
  always @(posedge clk) begin
    in_took <= in_ch.valid && in_ch.ready;
  end

  function automatic bit sender_idles();
    case (flow_mode)
      FLOW_SEND_IDLE: return $urandom_range(0, 99) < 82;
      FLOW_BOTH:      return $urandom_range(0, 99) < 33;
      default:        return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (flow_mode)
      FLOW_RECV_STALL: return $urandom_range(0, 99) < 82;
      FLOW_BOTH:       return $urandom_range(0, 99) < 33;
      default:         return 1'b0;
    endcase
  endfunction

  // The result side stalls at random, changing at the falling edge.
  always @(negedge clk) begin
    out_ch.ready <= !receiver_stalls();
  end

  // Mostly full-range values, with extremes and small values mixed in.
  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2, 3:    return 16'($urandom_range(0, 64)) - 16'sd32;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one sample and hold it until its transfer. Entered and left at a
  // falling edge; the caller assigns valid again in the step it returns in.
  task automatic send_sample(input logic signed [15:0] sample, input logic clr,
                             input logic last);
    while (sender_idles()) begin
      in_ch.valid         <= 1'b0;
      in_ch.sample_in     <= 16'($urandom);
      in_ch.clear_history <= 1'($urandom);
      in_ch.last_in_block <= 1'($urandom);
      @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.sample_in     <= sample;
    in_ch.clear_history <= clr;
    in_ch.last_in_block <= last;
    @(negedge clk);
    while (!in_took) @(negedge clk);
    samples_sent++;
  endtask

  // One block of random samples. Most blocks are well formed: an optional
  // clear at the start and a last marker at the end. The rest carry stray
  // clears, stray last markers, or run on without an end marker.
  task automatic send_block();
    int  len;
    bit  broken;
    logic clr;
    logic last;
    len    = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 24);
    broken = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < len; i++) begin
      if (broken) begin
        clr  = ($urandom_range(0, 9) == 0);
        last = ($urandom_range(0, 9) == 0);
      end else begin
        clr  = (i == 0) && ($urandom_range(0, 3) == 0);
        last = (i == len - 1);
      end
      send_sample(pick_sample(), clr, last);
    end
  endtask

  // Stop offering samples until every predicted result has arrived, then
  // let the block finish any sample that produces no result.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    in_ch.valid         = 1'b0;
    in_ch.sample_in     = '0;
    in_ch.clear_history = 1'b0;
    in_ch.last_in_block = 1'b0;
    out_ch.ready        = 1'b0;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: steps between the extremes to drive overshoot into
    // saturation, clear and last alone and together, and small values.
    send_sample(16'sh8000, 1'b1, 1'b0);
    repeat (6) send_sample(16'sh7fff, 1'b0, 1'b0);
    repeat (6) send_sample(16'sh8000, 1'b0, 1'b0);
    repeat (3) send_sample(16'sh7fff, 1'b0, 1'b0);
    send_sample(16'sh7fff, 1'b1, 1'b1);
    send_sample(16'sh0000, 1'b0, 1'b0);
    send_sample(16'sh0001, 1'b0, 1'b0);
    send_sample(16'shffff, 1'b0, 1'b1);
    send_sample(16'sh5555, 1'b0, 1'b0);
    send_sample(16'shaaaa, 1'b1, 1'b0);
    send_sample(16'sh0000, 1'b0, 1'b1);
    drain_results();

    // Random part, one flow-control mode after another.
    for (int m = 0; m < 4; m++) begin
      flow_mode = flow_mode_e'(m);
      while (samples_sent < 25 + ITEMS_PER_MODE * (m + 1)) send_block();
      drain_results();
    end

    if (mismatches == 0) begin
      $display("PASS iir_lowpass_decimator_unit");
    end else begin
      $display("FAIL iir_lowpass_decimator_unit");
    end
    $finish;
  end

endmodule

/* iir_lowpass_decimator_unit.f */
rtl/ild_pkg.sv
rtl/ild_ifs.sv
rtl/ild_cell.sv
rtl/ild_mac.sv
rtl/iir_lowpass_decimator_unit.sv
dv/ild_result_checker.sv
dv/tb_iir_lowpass_decimator_unit.sv
